### design/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg: shared types, tables and round functions for the aes-128 engine
// s-boxes, gf(2^8) helpers and the sequencer state type
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned BlockW = 128;
  localparam int unsigned HalfW  = 64;
  localparam int unsigned CfgIdxW = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegIvHigh  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIvLow   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMode    = 3'd4;

  typedef enum logic [2:0] {
    StKeyExp,
    StIdle,
    StRun,
    StOut
  } aes_state_e;

  typedef logic [7:0] byte_t;

  localparam byte_t FwdSub [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t RevSub [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic byte_t xt(byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte k of a block sits in bits [127-8k -: 8]
  function automatic byte_t bget(logic [BlockW-1:0] s, int k);
    return s[BlockW-1-8*k -: 8];
  endfunction

  // subbytes + shiftrows (+ mixcolumns when mix)
  function automatic logic [BlockW-1:0] fwd_round(logic [BlockW-1:0] s, logic mix);
    logic [BlockW-1:0] o;
    byte_t t [16];
    byte_t a0, a1, a2, a3;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[r+4*c] = FwdSub[bget(s, r + 4*((c+r)&3))];
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (mix) begin
        o[BlockW-1-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        o[BlockW-1-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
        o[BlockW-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
        o[BlockW-1-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end else begin
        o[BlockW-1-8*(4*c)   -: 8] = a0;
        o[BlockW-1-8*(4*c+1) -: 8] = a1;
        o[BlockW-1-8*(4*c+2) -: 8] = a2;
        o[BlockW-1-8*(4*c+3) -: 8] = a3;
      end
    end
    return o;
  endfunction

  function automatic logic [BlockW-1:0] inv_shift_sub(logic [BlockW-1:0] s);
    logic [BlockW-1:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[BlockW-1-8*(r+4*((c+r)&3)) -: 8] = RevSub[bget(s, r+4*c)];
    return o;
  endfunction

  function automatic logic [BlockW-1:0] inv_mix(logic [BlockW-1:0] s);
    logic [BlockW-1:0] o;
    byte_t a [4];
    byte_t x2 [4];
    byte_t x4 [4];
    byte_t x8 [4];
    byte_t m9 [4];
    byte_t mb [4];
    byte_t md [4];
    byte_t me [4];
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        a[i] = bget(s, 4*c+i);
        x2[i] = xt(a[i]); x4[i] = xt(x2[i]); x8[i] = xt(x4[i]);
        m9[i] = x8[i] ^ a[i];
        mb[i] = x8[i] ^ x2[i] ^ a[i];
        md[i] = x8[i] ^ x4[i] ^ a[i];
        me[i] = x8[i] ^ x4[i] ^ x2[i];
      end
      o[BlockW-1-8*(4*c)   -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
      o[BlockW-1-8*(4*c+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
      o[BlockW-1-8*(4*c+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
      o[BlockW-1-8*(4*c+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
    end
    return o;
  endfunction

  // one key schedule step: previous round key to next
  function automatic logic [BlockW-1:0] next_rk(logic [BlockW-1:0] k, byte_t rc);
    logic [31:0] w [4];
    logic [31:0] t;
    for (int i = 0; i < 4; i++) w[i] = k[BlockW-1-32*i -: 32];
    t = {FwdSub[w[3][23:16]] ^ rc, FwdSub[w[3][15:8]], FwdSub[w[3][7:0]],
         FwdSub[w[3][31:24]]};
    w[0] = w[0] ^ t;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    return {w[0], w[1], w[2], w[3]};
  endfunction

endpackage

### design/aes_round_unit.sv
// ----------------------------------------------------------------------------
// aes_round_unit: shared round datapath
// one forward or inverse round, with the round key added
// ----------------------------------------------------------------------------
module aes_round_unit
  import aes_pkg::*;
(
  input  logic [BlockW-1:0] state_i,
  input  logic [BlockW-1:0] rk_i,
  input  logic              dec_i,
  input  logic              final_i,
  output logic [BlockW-1:0] state_o
);

  logic [BlockW-1:0] inv_k;

  // inverse: shift/sub, add key, mix unless final
  always_comb begin
    inv_k = inv_shift_sub(state_i) ^ rk_i;
    if (dec_i) begin
      state_o = final_i ? inv_k : inv_mix(inv_k);
    end else begin
      state_o = fwd_round(state_i, !final_i) ^ rk_i;
    end
  end

endmodule

### design/aes128_ecb_cbc_block_cipher_top.sv
// ----------------------------------------------------------------------------
// aes128_ecb_cbc_block_cipher_top: aes-128 ecb/cbc engine
// one round per cycle on a shared round unit under a small sequencer
// ----------------------------------------------------------------------------
// usage
//   cfg port: cfg_we_i/cfg_idx_i/cfg_wdata_i write key, iv and mode while idle.
//   a key write re-expands the 11 round keys into a small store, one key a
//   cycle while the input is not ready. an iv write reloads the chain.
//   input beat: s_axis_tdata = {block_low, block_high}, tuser = func,
//   tlast = last_block. output beat: m_axis_tdata = {result_low,
//   result_high}, tlast = result_last.
//   for each block the initial key add is done on the accept edge, then ten
//   rounds go through the round unit, the last of which also loads the output
//   register; the result is held until the receiver takes it and the next
//   block can be accepted the cycle after.
//   a new block is not taken until the last result has been taken, as the
//   single round unit serves one block at a time.
//   after reset the zero key is expanded before the first accept.
// ----------------------------------------------------------------------------
module aes128_ecb_cbc_block_cipher_top
  import aes_pkg::*;
#(
  parameter int unsigned NUM_ROUNDS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [HalfW-1:0]   cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // fields: block_high [63:0], block_low [127:64]
  input  logic [BlockW-1:0]  s_axis_tdata,
  // fields: func
  input  logic               s_axis_tuser,
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // fields: result_high [63:0], result_low [127:64]
  output logic [BlockW-1:0]  m_axis_tdata,
  output logic               m_axis_tlast
);

  localparam int unsigned RkW = $clog2(NUM_ROUNDS + 1);

  aes_state_e state_q, state_d;
  logic [RkW-1:0] cnt_q, cnt_d;
  logic [7:0] rc_q;
  logic [HalfW-1:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic mode_q, dec_q, last_q;
  logic [BlockW-1:0] chain_q, work_q, in_q, res_q, exp_q;
  logic [BlockW-1:0] rk_mem [NUM_ROUNDS+1];
  logic [BlockW-1:0] rk_rd, round_out;
  logic [RkW-1:0] rd_idx;
  logic key_wr, accept, out_done;

  assign key_wr   = cfg_we_i && (cfg_idx_i == RegKeyHigh || cfg_idx_i == RegKeyLow);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_done = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == StIdle) && !key_wr;

  // round key read: forward counts up, inverse counts down
  assign rd_idx = dec_q ? RkW'(NUM_ROUNDS) - cnt_q : cnt_q;
  assign rk_rd  = rk_mem[rd_idx];

  aes_round_unit u_round (
    .state_i (work_q),
    .rk_i    (rk_rd),
    .dec_i   (dec_q),
    .final_i (cnt_q == RkW'(NUM_ROUNDS)),
    .state_o (round_out)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StKeyExp: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == RkW'(NUM_ROUNDS)) begin
          state_d = StIdle;
          cnt_d   = '0;
        end
      end
      StIdle: begin
        if (accept) begin
          state_d = StRun;
          cnt_d   = RkW'(1);
        end
      end
      StRun: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == RkW'(NUM_ROUNDS)) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_done) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    if (key_wr) begin
      state_d = StKeyExp;
      cnt_d   = RkW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StKeyExp;
      cnt_q   <= RkW'(1);
      rc_q    <= 8'h01;
      key_hi_q <= '0;
      key_lo_q <= '0;
      iv_hi_q <= '0;
      iv_lo_q <= '0;
      mode_q  <= 1'b0;
      chain_q <= '0;
      exp_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      // config writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegKeyHigh: key_hi_q <= cfg_wdata_i;
          RegKeyLow:  key_lo_q <= cfg_wdata_i;
          RegIvHigh: begin
            iv_hi_q <= cfg_wdata_i;
            chain_q <= {cfg_wdata_i, iv_lo_q};
          end
          RegIvLow: begin
            iv_lo_q <= cfg_wdata_i;
            chain_q <= {iv_hi_q, cfg_wdata_i};
          end
          RegMode: mode_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      // key expansion register
      if (key_wr) begin
        rc_q  <= 8'h01;
        exp_q <= (cfg_idx_i == RegKeyHigh) ? {cfg_wdata_i, key_lo_q}
                                           : {key_hi_q, cfg_wdata_i};
      end else if (state_q == StKeyExp) begin
        exp_q <= next_rk(exp_q, rc_q);
        rc_q  <= xt(rc_q);
      end
      // chain update on result
      if (state_q == StRun && cnt_q == RkW'(NUM_ROUNDS) && mode_q) begin
        chain_q <= dec_q ? in_q : round_out;
      end
    end
  end

  // round key store; key 0 is the raw key, also taken on the first
  // expansion cycle so the expansion after reset fills it
  always_ff @(posedge clk_i) begin
    if (key_wr) begin
      rk_mem[0] <= (cfg_idx_i == RegKeyHigh) ? {cfg_wdata_i, key_lo_q}
                                             : {key_hi_q, cfg_wdata_i};
    end else if (state_q == StKeyExp) begin
      if (cnt_q == RkW'(1)) rk_mem[0] <= exp_q;
      rk_mem[cnt_q] <= next_rk(exp_q, rc_q);
    end
  end

  // datapath: initial add at accept, rounds, then the output register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dec_q  <= s_axis_tuser;
      last_q <= s_axis_tlast;
      in_q   <= {s_axis_tdata[HalfW-1:0], s_axis_tdata[BlockW-1:HalfW]};
      work_q <= ({s_axis_tdata[HalfW-1:0], s_axis_tdata[BlockW-1:HalfW]}
                 ^ ((mode_q && !s_axis_tuser) ? chain_q : '0))
                ^ rk_mem[s_axis_tuser ? RkW'(NUM_ROUNDS) : RkW'(0)];
    end else if (state_q == StRun) begin
      work_q <= round_out;
      if (cnt_q == RkW'(NUM_ROUNDS)) begin
        res_q <= round_out ^ ((mode_q && dec_q) ? chain_q : '0);
      end
    end
  end

  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {res_q[HalfW-1:0], res_q[BlockW-1:HalfW]};
  assign m_axis_tlast  = last_q;

endmodule

### design/aes_checker.sv
// ----------------------------------------------------------------------------
// aes_checker: port-level checks for the aes engine
// handshake and sequencing properties seen at the top level
// ----------------------------------------------------------------------------
module aes_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);

  // no new beat taken while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready with result pending");

  // result held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");

  // a result is absent at each of the sampled points after its input is accepted
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid ##1 !m_axis_tvalid ##8 !m_axis_tvalid)
    else $error("result too early");

  // busy after accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready during rounds");

endmodule

bind aes128_ecb_cbc_block_cipher_top aes_checker u_aes_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
